// File: src/vsfm_pkg.sv
// Package for the voxel surface face mask block: register indexes, class bits,
// face bit positions and the queued decision word. No dependencies.
`timescale 1ns / 1ps

package vsfm_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_DIM_X       = 3'd0,
    REG_DIM_Y       = 3'd1,
    REG_DIM_Z       = 3'd2,
    REG_SOLID_VALUE = 3'd3,
    REG_EMPTY_VALUE = 3'd4
  } cfg_reg_t;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  // Class bit positions of one window entry
  localparam int CLS_SOLID = 0;
  localparam int CLS_EMPTY = 1;

  // Face bit positions of the mask
  localparam int FACE_XP = 0;
  localparam int FACE_XM = 1;
  localparam int FACE_YP = 2;
  localparam int FACE_YM = 3;
  localparam int FACE_ZP = 4;
  localparam int FACE_ZM = 5;

  // Decision queue between the front and back parts
  localparam int FQ_DEPTH = 4;
  localparam int FQ_AW    = 2;
  localparam int FQ_CW    = 3;

  // One decided solid voxel: boundary flags and neighbor empty flags per face
  typedef struct packed {
    logic [7:0] pos_x;
    logic [7:0] pos_y;
    logic [9:0] pos_z;
    logic [5:0] at_bound;
    logic [5:0] nb_empty;
    logic       last;
  } face_item_t;

endpackage

// File: src/vsfm_ring_bank.sv
// One bank of the class ring window: one write port, two registered read ports.
// Depends on nothing; instantiated by vsfm_front.
`timescale 1ns / 1ps

module vsfm_ring_bank #(
  parameter int DEPTH = 131073,
  parameter int AW    = 18
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [1:0]    wr_data,
  input  logic [AW-1:0] rd_addr0,
  input  logic [AW-1:0] rd_addr1,
  output logic [1:0]    rd_data0,
  output logic [1:0]    rd_data1
);

  logic [1:0] mem [DEPTH];

  // Store the class bits of the arriving word
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read both taps, old data on a same-address write
  always_ff @(posedge clk) begin
    rd_data0 <= mem[rd_addr0];
    rd_data1 <= mem[rd_addr1];
  end

endmodule

// File: src/vsfm_front.sv
// Front part: configuration registers, word accept and classification, raster
// counters, ring window addressing and reads. Uses vsfm_pkg and vsfm_ring_bank.
`timescale 1ns / 1ps

module vsfm_front import vsfm_pkg::*; #(
  parameter int MAX_DIM_X = 256,
  parameter int MAX_DIM_Y = 256,
  parameter int MAX_DIM_Z = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_func,
  input  logic [7:0]            in_voxel_value,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic [FQ_CW-1:0]      fq_count,
  output logic                  push_vld,
  output face_item_t            push_item
);

  localparam int DXW = $clog2(MAX_DIM_X + 1);
  localparam int DYW = $clog2(MAX_DIM_Y + 1);
  localparam int DZW = $clog2(MAX_DIM_Z + 1);
  localparam int XW  = (MAX_DIM_X > 1) ? $clog2(MAX_DIM_X) : 1;
  localparam int YW  = (MAX_DIM_Y > 1) ? $clog2(MAX_DIM_Y) : 1;
  localparam int ZW  = (MAX_DIM_Z > 1) ? $clog2(MAX_DIM_Z) : 1;
  localparam int PW  = $clog2(MAX_DIM_X * MAX_DIM_Y + 1);
  localparam int WIN_DEPTH = 2 * MAX_DIM_X * MAX_DIM_Y + 1;
  localparam int AW  = $clog2(WIN_DEPTH);
  localparam longint unsigned ACNT_MAX =
    longint'(MAX_DIM_X) * longint'(MAX_DIM_Y) * longint'(MAX_DIM_Z + 1);
  localparam int CW  = $clog2(ACNT_MAX + 1);
  localparam int RST_DX = (MAX_DIM_X < 256) ? MAX_DIM_X : 256;
  localparam int RST_DY = (MAX_DIM_Y < 256) ? MAX_DIM_Y : 256;
  localparam int RST_DZ = (MAX_DIM_Z < 1024) ? MAX_DIM_Z : 1024;
  localparam int RST_PLANE = RST_DX * RST_DY;

  function automatic logic [31:0] clamp_dim(input logic [31:0] v, input logic [31:0] hi);
    logic [31:0] r;
    r = v;
    if (v == 32'd0) begin
      r = 32'd1;
    end else if (v > hi) begin
      r = hi;
    end
    return r;
  endfunction

  // Configuration registers (dimensions held already saturated)
  logic [DXW-1:0] dx_r, dx_nxt;
  logic [DYW-1:0] dy_r, dy_nxt;
  logic [DZW-1:0] dz_r, dz_nxt;
  logic [PW-1:0]  plane_r, plane_nxt;
  logic [7:0]     solid_r, solid_nxt;
  logic [7:0]     empty_r, empty_nxt;

  // Raster state
  logic [CW-1:0] arrival_r, arrival_nxt;
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [XW-1:0] emit_x_r, emit_x_nxt;
  logic [YW-1:0] emit_y_r, emit_y_nxt;
  logic [ZW-1:0] emit_z_r, emit_z_nxt;

  // Stage A: accepted word with its decision context
  logic          a_vld_r;
  logic [AW-1:0] a_cur_r;
  logic [1:0]    a_cls_r;
  logic          a_decide_r;
  logic [AW-1:0] a_ctr_r;
  logic [AW-1:0] a_zm_r;
  logic [7:0]    a_pos_x_r;
  logic [7:0]    a_pos_y_r;
  logic [9:0]    a_pos_z_r;
  logic [5:0]    a_bound_r;
  logic          a_last_r;

  // Stage B: reads in flight, data at the bank outputs
  logic          b_vld_r;
  logic          b_decide_r;
  logic [1:0]    b_wcls_r;
  logic          b_byp_xp_r;
  logic          b_byp_yp_r;
  logic [7:0]    b_pos_x_r;
  logic [7:0]    b_pos_y_r;
  logic [9:0]    b_pos_z_r;
  logic [5:0]    b_bound_r;
  logic          b_last_r;

  logic          acc;
  logic          act;
  logic [1:0]    cls_new;
  logic          decide;
  logic          x_hi, x_lo, y_hi, y_lo, z_hi, z_lo;
  logic          last;
  logic [AW:0]   ctr_diff;
  logic [AW:0]   zm_diff;
  logic [AW-1:0] ctr_addr;
  logic [AW-1:0] zm_addr;
  logic [AW-1:0] xp_addr, xm_addr, yp_addr, ym_addr;
  logic [AW:0]   yp_sum;
  logic [AW:0]   ym_diff;
  logic [FQ_CW:0] credit_use;
  logic [1:0]    rd_ctr, rd_zm, rd_xp, rd_xm, rd_yp, rd_ym;
  logic [1:0]    cls_xp, cls_yp;

  // Write configuration registers and keep the plane size current
  always_comb begin
    dx_nxt    = dx_r;
    dy_nxt    = dy_r;
    dz_nxt    = dz_r;
    plane_nxt = plane_r;
    solid_nxt = solid_r;
    empty_nxt = empty_r;
    if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_DIM_X: begin
          dx_nxt    = DXW'(clamp_dim(32'(cfg_wdata[8:0]), 32'(MAX_DIM_X)));
          plane_nxt = PW'(32'(dx_nxt) * 32'(dy_r));
        end
        REG_DIM_Y: begin
          dy_nxt    = DYW'(clamp_dim(32'(cfg_wdata[8:0]), 32'(MAX_DIM_Y)));
          plane_nxt = PW'(32'(dx_r) * 32'(dy_nxt));
        end
        REG_DIM_Z: begin
          dz_nxt = DZW'(clamp_dim(32'(cfg_wdata[10:0]), 32'(MAX_DIM_Z)));
        end
        REG_SOLID_VALUE: begin
          solid_nxt = cfg_wdata[7:0];
        end
        REG_EMPTY_VALUE: begin
          empty_nxt = cfg_wdata[7:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dx_r    <= DXW'(RST_DX);
      dy_r    <= DYW'(RST_DY);
      dz_r    <= DZW'(RST_DZ);
      plane_r <= PW'(RST_PLANE);
      solid_r <= 8'd255;
      empty_r <= 8'd0;
    end else begin
      dx_r    <= dx_nxt;
      dy_r    <= dy_nxt;
      dz_r    <= dz_nxt;
      plane_r <= plane_nxt;
      solid_r <= solid_nxt;
      empty_r <= empty_nxt;
    end
  end

  // Hold off input when the queue could not take every word in flight
  assign credit_use = (FQ_CW+1)'(fq_count) + (FQ_CW+1)'(a_vld_r) + (FQ_CW+1)'(b_vld_r);
  assign in_stall   = credit_use >= (FQ_CW+1)'(FQ_DEPTH);

  // Accept and classify; drop a flush word while no volume is in progress
  assign acc = in_valid && !in_stall;
  assign act = acc && !(in_func && (arrival_r == '0));

  always_comb begin
    cls_new = 2'b00;
    if (!in_func) begin
      cls_new[CLS_SOLID] = (in_voxel_value == solid_r);
      cls_new[CLS_EMPTY] = (in_voxel_value == empty_r);
    end
  end

  assign decide = arrival_r >= CW'(plane_r);
  assign x_hi   = (32'(emit_x_r) + 32'd1) >= 32'(dx_r);
  assign y_hi   = (32'(emit_y_r) + 32'd1) >= 32'(dy_r);
  assign z_hi   = (32'(emit_z_r) + 32'd1) >= 32'(dz_r);
  assign x_lo   = (emit_x_r == '0);
  assign y_lo   = (emit_y_r == '0);
  assign z_lo   = (emit_z_r == '0);
  assign last   = x_hi && y_hi && z_hi;

  // Advance the arrival count, ring pointer and decided coordinates
  always_comb begin
    arrival_nxt = arrival_r;
    wr_ptr_nxt  = wr_ptr_r;
    emit_x_nxt  = emit_x_r;
    emit_y_nxt  = emit_y_r;
    emit_z_nxt  = emit_z_r;
    if (act) begin
      if (decide && last) begin
        arrival_nxt = '0;
        wr_ptr_nxt  = '0;
        emit_x_nxt  = '0;
        emit_y_nxt  = '0;
        emit_z_nxt  = '0;
      end else begin
        arrival_nxt = arrival_r + CW'(1);
        wr_ptr_nxt  = (wr_ptr_r == AW'(WIN_DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
        if (decide) begin
          if (x_hi) begin
            emit_x_nxt = '0;
            if (y_hi) begin
              emit_y_nxt = '0;
              emit_z_nxt = emit_z_r + ZW'(1);
            end else begin
              emit_y_nxt = emit_y_r + YW'(1);
            end
          end else begin
            emit_x_nxt = emit_x_r + XW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arrival_r <= '0;
      wr_ptr_r  <= '0;
      emit_x_r  <= '0;
      emit_y_r  <= '0;
      emit_z_r  <= '0;
    end else begin
      arrival_r <= arrival_nxt;
      wr_ptr_r  <= wr_ptr_nxt;
      emit_x_r  <= emit_x_nxt;
      emit_y_r  <= emit_y_nxt;
      emit_z_r  <= emit_z_nxt;
    end
  end

  // Locate the decided voxel one plane back and its lower-z neighbor two planes back
  assign ctr_diff = {1'b0, wr_ptr_r} - (AW+1)'(plane_r);
  assign ctr_addr = ctr_diff[AW] ? AW'(ctr_diff + (AW+1)'(WIN_DEPTH)) : ctr_diff[AW-1:0];
  assign zm_diff  = {1'b0, wr_ptr_r} - ((AW+1)'(plane_r) << 1);
  assign zm_addr  = zm_diff[AW] ? AW'(zm_diff + (AW+1)'(WIN_DEPTH)) : zm_diff[AW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else begin
      a_vld_r <= act;
    end
  end

  always_ff @(posedge clk) begin
    if (act) begin
      a_cur_r    <= wr_ptr_r;
      a_cls_r    <= cls_new;
      a_decide_r <= decide;
      a_ctr_r    <= ctr_addr;
      a_zm_r     <= zm_addr;
      a_pos_x_r  <= 8'(emit_x_r);
      a_pos_y_r  <= 8'(emit_y_r);
      a_pos_z_r  <= 10'(emit_z_r);
      a_last_r   <= last;
      a_bound_r[FACE_XP] <= x_hi;
      a_bound_r[FACE_XM] <= x_lo;
      a_bound_r[FACE_YP] <= y_hi;
      a_bound_r[FACE_YM] <= y_lo;
      a_bound_r[FACE_ZP] <= z_hi;
      a_bound_r[FACE_ZM] <= z_lo;
    end
  end

  // Neighbor addresses in the row and across rows, wrapped into the ring
  assign xp_addr = (a_ctr_r == AW'(WIN_DEPTH - 1)) ? '0 : a_ctr_r + AW'(1);
  assign xm_addr = (a_ctr_r == '0) ? AW'(WIN_DEPTH - 1) : a_ctr_r - AW'(1);
  assign yp_sum  = {1'b0, a_ctr_r} + (AW+1)'(dx_r);
  assign yp_addr = (yp_sum >= (AW+1)'(WIN_DEPTH)) ? AW'(yp_sum - (AW+1)'(WIN_DEPTH))
                                                  : yp_sum[AW-1:0];
  assign ym_diff = {1'b0, a_ctr_r} - (AW+1)'(dx_r);
  assign ym_addr = ym_diff[AW] ? AW'(ym_diff + (AW+1)'(WIN_DEPTH)) : ym_diff[AW-1:0];

  // Three copies of the window so that all six taps read in the same cycle
  vsfm_ring_bank #(.DEPTH(WIN_DEPTH), .AW(AW)) u_bank_z (
    .clk      (clk),
    .wr_en    (a_vld_r),
    .wr_addr  (a_cur_r),
    .wr_data  (a_cls_r),
    .rd_addr0 (a_ctr_r),
    .rd_addr1 (a_zm_r),
    .rd_data0 (rd_ctr),
    .rd_data1 (rd_zm)
  );

  vsfm_ring_bank #(.DEPTH(WIN_DEPTH), .AW(AW)) u_bank_x (
    .clk      (clk),
    .wr_en    (a_vld_r),
    .wr_addr  (a_cur_r),
    .wr_data  (a_cls_r),
    .rd_addr0 (xp_addr),
    .rd_addr1 (xm_addr),
    .rd_data0 (rd_xp),
    .rd_data1 (rd_xm)
  );

  vsfm_ring_bank #(.DEPTH(WIN_DEPTH), .AW(AW)) u_bank_y (
    .clk      (clk),
    .wr_en    (a_vld_r),
    .wr_addr  (a_cur_r),
    .wr_data  (a_cls_r),
    .rd_addr0 (yp_addr),
    .rd_addr1 (ym_addr),
    .rd_data0 (rd_yp),
    .rd_data1 (rd_ym)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else begin
      b_vld_r <= a_vld_r;
    end
  end

  // Carry context alongside the reads; flag taps that hit the word being written
  always_ff @(posedge clk) begin
    if (a_vld_r) begin
      b_decide_r <= a_decide_r;
      b_wcls_r   <= a_cls_r;
      b_byp_xp_r <= (xp_addr == a_cur_r);
      b_byp_yp_r <= (yp_addr == a_cur_r);
      b_pos_x_r  <= a_pos_x_r;
      b_pos_y_r  <= a_pos_y_r;
      b_pos_z_r  <= a_pos_z_r;
      b_bound_r  <= a_bound_r;
      b_last_r   <= a_last_r;
    end
  end

  // Forward the just-written class when a tap lands on it (one-row planes)
  assign cls_xp = b_byp_xp_r ? b_wcls_r : rd_xp;
  assign cls_yp = b_byp_yp_r ? b_wcls_r : rd_yp;

  // Queue only decided solid voxels
  assign push_vld = b_vld_r && b_decide_r && rd_ctr[CLS_SOLID];

  always_comb begin
    push_item.pos_x    = b_pos_x_r;
    push_item.pos_y    = b_pos_y_r;
    push_item.pos_z    = b_pos_z_r;
    push_item.at_bound = b_bound_r;
    push_item.last     = b_last_r;
    push_item.nb_empty[FACE_XP] = cls_xp[CLS_EMPTY];
    push_item.nb_empty[FACE_XM] = rd_xm[CLS_EMPTY];
    push_item.nb_empty[FACE_YP] = cls_yp[CLS_EMPTY];
    push_item.nb_empty[FACE_YM] = rd_ym[CLS_EMPTY];
    push_item.nb_empty[FACE_ZP] = b_wcls_r[CLS_EMPTY];
    push_item.nb_empty[FACE_ZM] = rd_zm[CLS_EMPTY];
  end

endmodule

// File: src/vsfm_fifo.sv
// Short decision queue between the front and back parts.
// Uses vsfm_pkg for the queued word and the depth constants.
`timescale 1ns / 1ps

module vsfm_fifo import vsfm_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_vld,
  input  face_item_t       push_item,
  input  logic             pop,
  output logic             head_vld,
  output face_item_t       head_item,
  output logic [FQ_CW-1:0] count
);

  face_item_t       slot_r [FQ_DEPTH];
  logic [FQ_AW-1:0] wptr_r, wptr_nxt;
  logic [FQ_AW-1:0] rptr_r, rptr_nxt;
  logic [FQ_CW-1:0] count_r, count_nxt;

  // Advance pointers and occupancy
  always_comb begin
    wptr_nxt  = push_vld ? wptr_r + FQ_AW'(1) : wptr_r;
    rptr_nxt  = pop ? rptr_r + FQ_AW'(1) : rptr_r;
    count_nxt = count_r + FQ_CW'(push_vld) - FQ_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  // Store the pushed word
  always_ff @(posedge clk) begin
    if (push_vld) begin
      slot_r[wptr_r] <= push_item;
    end
  end

  assign head_vld  = (count_r != '0);
  assign head_item = slot_r[rptr_r];
  assign count     = count_r;

endmodule

// File: src/vsfm_back.sv
// Back part: builds the face mask from queued decisions, drops empty masks and
// holds the result word in the output register. Uses vsfm_pkg.
`timescale 1ns / 1ps

module vsfm_back import vsfm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       head_vld,
  input  face_item_t head_item,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_pos_x,
  output logic [7:0] out_pos_y,
  output logic [9:0] out_pos_z,
  output logic [5:0] out_face_mask,
  output logic       out_volume_end
);

  logic       out_valid_r, out_valid_nxt;
  logic [7:0] pos_x_r;
  logic [7:0] pos_y_r;
  logic [9:0] pos_z_r;
  logic [5:0] mask_r;
  logic       end_r;
  logic [5:0] mask;
  logic       take;

  // A face shows where the neighbor is air or outside the volume
  assign mask = head_item.at_bound | head_item.nb_empty;

  // Load when the output register is free or being drained
  assign take = !out_valid_r || !out_stall;
  assign pop  = head_vld && take;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (take) begin
      out_valid_nxt = head_vld && (mask != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      pos_x_r <= head_item.pos_x;
      pos_y_r <= head_item.pos_y;
      pos_z_r <= head_item.pos_z;
      mask_r  <= mask;
      end_r   <= head_item.last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pos_x      = pos_x_r;
  assign out_pos_y      = pos_y_r;
  assign out_pos_z      = pos_z_r;
  assign out_face_mask  = mask_r;
  assign out_volume_end = end_r;

endmodule

// File: src/voxel_surface_face_mask_core.sv
// Voxel surface face mask core: top level joining front, decision queue and back.
// Throughput one word per cycle while in_stall is low; the three window banks each
// take one write and two reads per cycle. A voxel is decided when the word one plane
// later arrives; its result passes stages A and B, the queue and the output register.
// Reset (rst_n low, synchronous) clears counters, pipeline and queue; window undefined.
`timescale 1ns / 1ps

module voxel_surface_face_mask_core import vsfm_pkg::*; #(
  parameter int MAX_DIM_X = 256,
  parameter int MAX_DIM_Y = 256,
  parameter int MAX_DIM_Z = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_func,
  input  logic [7:0]            in_voxel_value,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            out_pos_x,
  output logic [7:0]            out_pos_y,
  output logic [9:0]            out_pos_z,
  output logic [5:0]            out_face_mask,
  output logic                  out_volume_end,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic             push_vld;
  face_item_t       push_item;
  logic             head_vld;
  face_item_t       head_item;
  logic             pop;
  logic [FQ_CW-1:0] fq_count;

  vsfm_front #(
    .MAX_DIM_X (MAX_DIM_X),
    .MAX_DIM_Y (MAX_DIM_Y),
    .MAX_DIM_Z (MAX_DIM_Z)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_func        (in_func),
    .in_voxel_value (in_voxel_value),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .fq_count       (fq_count),
    .push_vld       (push_vld),
    .push_item      (push_item)
  );

  vsfm_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_vld  (push_vld),
    .push_item (push_item),
    .pop       (pop),
    .head_vld  (head_vld),
    .head_item (head_item),
    .count     (fq_count)
  );

  vsfm_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head_vld       (head_vld),
    .head_item      (head_item),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_pos_x      (out_pos_x),
    .out_pos_y      (out_pos_y),
    .out_pos_z      (out_pos_z),
    .out_face_mask  (out_face_mask),
    .out_volume_end (out_volume_end)
  );

`ifndef NO_ASSERTIONS
  // The input credit must keep the queue from overflowing
  a_fq_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push_vld && !pop && (fq_count == FQ_CW'(FQ_DEPTH))))
    else $error("decision queue overflow");

  // The back part never pops an empty queue
  a_fq_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (fq_count != '0))
    else $error("decision queue underflow");

  // A delivered word always carries at least one visible face
  a_mask_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_face_mask != '0))
    else $error("result word with empty face mask");
`endif

endmodule
